// ===== rtl/psc_pkg.sv =====
// Package: shared types, codes and signal constants for the signal controller.
`timescale 1ns / 1ps

package psc_pkg;

   localparam int PROCS_DEF   = 64;
   localparam int SIGNALS_DEF = 64;
   localparam int MASK_W      = 64;

   localparam logic [6:0] SIG_KILL  = 7'd9;
   localparam logic [6:0] SIG_STOP  = 7'd19;
   localparam logic [6:0] SIG_CONT  = 7'd18;
   localparam logic [6:0] SIG_TSTP  = 7'd20;
   localparam logic [6:0] SIG_TTIN  = 7'd21;
   localparam logic [6:0] SIG_TTOU  = 7'd22;
   localparam logic [6:0] SIG_CHLD  = 7'd17;
   localparam logic [6:0] SIG_URG   = 7'd23;
   localparam logic [6:0] SIG_WINCH = 7'd28;

   localparam logic [MASK_W-1:0] PROT_MASK =
      (MASK_W'(1) << SIG_KILL) | (MASK_W'(1) << SIG_STOP);

   typedef enum logic [2:0] {
      CMD_SEND     = 3'd0,
      CMD_REGISTER = 3'd1,
      CMD_BLOCK    = 3'd2,
      CMD_UNBLOCK  = 3'd3,
      CMD_SET_MASK = 3'd4,
      CMD_DISPATCH = 3'd5,
      CMD_QUERY    = 3'd6,
      CMD_UNKNOWN  = 3'd7
   } cmd_type;

   typedef enum logic [3:0] {
      ST_OK           = 4'd0,
      ST_BAD_ARG      = 4'd1,
      ST_PROTECTED    = 4'd2,
      ST_NO_PROC      = 4'd3,
      ST_BAD_HOW      = 4'd4,
      ST_NONE_PENDING = 4'd5,
      ST_IGNORED      = 4'd6,
      ST_DEF_TERM     = 4'd7,
      ST_DEF_IGNORE   = 4'd8,
      ST_DEF_STOP     = 4'd9,
      ST_USER         = 4'd10
   } status_type;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_READY = 2'd1,
      ACT_STOP  = 2'd2,
      ACT_TERM  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      HDL_DEFAULT = 2'd0,
      HDL_IGNORE  = 2'd1,
      HDL_USER    = 2'd2,
      HDL_INVALID = 2'd3
   } handler_type;

   typedef enum logic [1:0] {
      HOW_REPLACE = 2'd0,
      HOW_ADD     = 2'd1,
      HOW_REMOVE  = 2'd2,
      HOW_INVALID = 2'd3
   } how_type;

   typedef enum logic [1:0] {
      DK_TERM   = 2'd0,
      DK_IGNORE = 2'd1,
      DK_STOP   = 2'd2
   } defkind_type;

   typedef struct packed {
      logic              proc_held;
      logic              proc_exists;
      logic [MASK_W-1:0] mask_bits;
      logic [1:0]        mask_how;
      logic [1:0]        handler_class;
      logic [6:0]        signal_number;
      logic [7:0]        proc_id;
      logic [2:0]        command;
   } req_type;

   typedef struct packed {
      logic [MASK_W-1:0] blocked_out;
      logic [MASK_W-1:0] pending_out;
      action_type        proc_action;
      logic [5:0]        picked_signal;
      logic [1:0]        old_handler;
      status_type        status;
   } result_type;

   function automatic defkind_type default_kind(input logic [6:0] sig);
      defkind_type k;
      case (sig) inside
         SIG_CHLD, SIG_URG, SIG_WINCH, SIG_CONT: k = DK_IGNORE;
         SIG_STOP, SIG_TSTP, SIG_TTIN, SIG_TTOU: k = DK_STOP;
         default:                                k = DK_TERM;
      endcase
      return k;
   endfunction

endpackage

// ===== rtl/posix_signal_controller.sv =====
// Top level: stream ports, two-step sequencer and result register.
// For each transaction the process row (pending mask, blocked mask and the
// handler classes of all signals) is read from the state memory in the cycle
// of acceptance, and in the next cycle it is modified, written back and the
// result is registered. A new request is taken only in the idle state, once
// the result register is free or is being emptied, so no new transaction is
// taken before the last one is executed. Reset takes effect at once through
// one valid bit per process row; no clearing pass is needed.
`timescale 1ns / 1ps

module posix_signal_controller
   import psc_pkg::*;
#(
   parameter int PROCS   = PROCS_DEF,
   parameter int SIGNALS = SIGNALS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command, proc_id, signal_number, handler_class, mask_how, mask_bits,
   // proc_exists, proc_held
   input  logic [87:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, old_handler, picked_signal, proc_action, pending_out,
   // blocked_out, two zero bits
   output logic [143:0] rsp_tdata
);

   localparam int AW = $clog2(PROCS);
   localparam int HW = 2 * SIGNALS;

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type         state_ff;
   req_type           req_ff;
   logic              rsp_valid_ff;
   result_type        rsp_ff;
   logic              accept;
   req_type           req_in;
   logic [MASK_W-1:0] rd_pend;
   logic [MASK_W-1:0] rd_blk;
   logic [HW-1:0]     rd_hdl;
   logic              ex_wr;
   logic [MASK_W-1:0] npend;
   logic [MASK_W-1:0] nblk;
   logic [HW-1:0]     nhdl;
   result_type        ex_rsp;

   assign req_in     = req_type'(req_tdata);
   assign req_tready = !reset && (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff};

   psc_store #(.PROCS(PROCS), .SIGNALS(SIGNALS)) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_in.proc_id[AW-1:0]),
      .wr_en   (ex_wr && (state_ff == S_EXEC)),
      .wr_addr (req_ff.proc_id[AW-1:0]),
      .wr_pend (npend),
      .wr_blk  (nblk),
      .wr_hdl  (nhdl),
      .rd_pend (rd_pend),
      .rd_blk  (rd_blk),
      .rd_hdl  (rd_hdl)
   );

   psc_exec #(.PROCS(PROCS), .SIGNALS(SIGNALS)) u_exec (
      .req   (req_ff),
      .pend  (rd_pend),
      .blk   (rd_blk),
      .hdl   (rd_hdl),
      .wr_en (ex_wr),
      .npend (npend),
      .nblk  (nblk),
      .nhdl  (nhdl),
      .rsp   (ex_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (rsp_valid_ff && rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (accept) begin
                  req_ff   <= req_in;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               rsp_ff       <= ex_rsp;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_exec_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EXEC)
      else $error("accepted transaction not executed");

   a_no_accept_in_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC |-> !req_tready)
      else $error("request taken while executing");

   a_result_free_in_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC |-> !rsp_valid_ff)
      else $error("result register occupied during execute");

   a_result_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC))
      else $error("result produced outside execute");

endmodule

// ===== rtl/psc_store.sv =====
// Per-process state memory: pending, blocked and handler row, with row valid bits.
`timescale 1ns / 1ps

module psc_store
   import psc_pkg::*;
#(
   parameter int PROCS   = PROCS_DEF,
   parameter int SIGNALS = SIGNALS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_en,
   input  logic [$clog2(PROCS)-1:0] rd_addr,
   input  logic                   wr_en,
   input  logic [$clog2(PROCS)-1:0] wr_addr,
   input  logic [MASK_W-1:0]      wr_pend,
   input  logic [MASK_W-1:0]      wr_blk,
   input  logic [2*SIGNALS-1:0]   wr_hdl,
   output logic [MASK_W-1:0]      rd_pend,
   output logic [MASK_W-1:0]      rd_blk,
   output logic [2*SIGNALS-1:0]   rd_hdl
);

   localparam int ROW_W = 2 * MASK_W + 2 * SIGNALS;

   logic [ROW_W-1:0] mem [PROCS];
   logic [PROCS-1:0] row_valid_ff;
   logic [ROW_W-1:0] rd_row_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_hdl, wr_blk, wr_pend};
      end
      if (rd_en) begin
         rd_row_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   // never-written rows read as reset state
   assign rd_pend = rd_valid_ff ? rd_row_ff[MASK_W-1:0] : '0;
   assign rd_blk  = rd_valid_ff ? rd_row_ff[2*MASK_W-1:MASK_W] : '0;
   assign rd_hdl  = rd_valid_ff ? rd_row_ff[ROW_W-1:2*MASK_W] : '0;

endmodule

// ===== rtl/psc_exec.sv =====
// Command logic: modifies one process row and forms the result.
`timescale 1ns / 1ps

module psc_exec
   import psc_pkg::*;
#(
   parameter int PROCS   = PROCS_DEF,
   parameter int SIGNALS = SIGNALS_DEF
) (
   input  req_type              req,
   input  logic [MASK_W-1:0]    pend,
   input  logic [MASK_W-1:0]    blk,
   input  logic [2*SIGNALS-1:0] hdl,
   output logic                 wr_en,
   output logic [MASK_W-1:0]    npend,
   output logic [MASK_W-1:0]    nblk,
   output logic [2*SIGNALS-1:0] nhdl,
   output result_type           rsp
);

   localparam int SW = $clog2(SIGNALS);
   localparam int HW = 2 * SIGNALS;
   localparam logic [MASK_W-1:0] SPAN =
      (SIGNALS >= MASK_W) ? {MASK_W{1'b1}} : ((MASK_W'(1) << SIGNALS) - MASK_W'(1));
   localparam logic [MASK_W-1:0] VALID_MASK = SPAN & ~MASK_W'(1);

   logic              pid_ok;
   logic              sig_ok;
   logic              sig_prot;
   logic [SW-1:0]     sidx;
   logic [MASK_W-1:0] sig_bit;
   logic [MASK_W-1:0] sel;
   logic [MASK_W-1:0] ready;
   logic [5:0]        pick;
   logic [1:0]        hcur;
   logic [1:0]        hpick;
   cmd_type           cmd;

   assign pid_ok   = {1'b0, req.proc_id} < 9'(PROCS);
   assign sig_ok   = (req.signal_number != 7'd0) && (req.signal_number < 7'(SIGNALS));
   assign sig_prot = (req.signal_number == SIG_KILL) || (req.signal_number == SIG_STOP);
   assign sidx     = req.signal_number[SW-1:0];
   assign sig_bit  = MASK_W'(1) << req.signal_number[5:0];
   assign sel      = req.mask_bits & VALID_MASK;
   assign ready    = pend & ~blk & VALID_MASK;
   assign hcur     = hdl[{sidx, 1'b0} +: 2];
   assign hpick    = hdl[{pick[SW-1:0], 1'b0} +: 2];
   assign cmd      = cmd_type'(req.command);

   always_comb begin
      pick = 6'd0;
      for (int i = SIGNALS - 1; i >= 1; i--) begin
         if (ready[i]) begin
            pick = 6'(i);
         end
      end
   end

   always_comb begin
      wr_en = 1'b0;
      npend = pend;
      nblk  = blk;
      nhdl  = hdl;
      rsp   = '0;
      rsp.status = ST_OK;
      unique case (cmd) inside
         CMD_SEND: begin
            if (!sig_ok) begin
               rsp.status = ST_BAD_ARG;
            end else begin
               npend = pend | sig_bit;
               wr_en = 1'b1;
               if (!req.proc_exists) begin
                  rsp.status = ST_NO_PROC;
               end else if (req.signal_number == SIG_KILL) begin
                  rsp.proc_action = ACT_TERM;
               end else if (req.signal_number == SIG_STOP || req.signal_number == SIG_TSTP ||
                            req.signal_number == SIG_TTIN ||
                            req.signal_number == SIG_TTOU) begin
                  rsp.proc_action = ACT_STOP;
               end else if (req.signal_number == SIG_CONT && req.proc_held) begin
                  rsp.proc_action = ACT_READY;
               end
            end
         end
         CMD_REGISTER: begin
            if (!sig_ok || req.handler_class == HDL_INVALID) begin
               rsp.status = ST_BAD_ARG;
            end else if (sig_prot) begin
               rsp.status = ST_PROTECTED;
            end else begin
               rsp.old_handler = hcur;
               nhdl  = (hdl & ~(HW'(3) << {sidx, 1'b0})) |
                       (HW'(req.handler_class) << {sidx, 1'b0});
               wr_en = 1'b1;
            end
         end
         CMD_BLOCK, CMD_UNBLOCK: begin
            if (!sig_ok) begin
               rsp.status = ST_BAD_ARG;
            end else if (sig_prot) begin
               rsp.status = ST_PROTECTED;
            end else begin
               nblk  = (cmd == CMD_BLOCK) ? (blk | sig_bit) : (blk & ~sig_bit);
               wr_en = 1'b1;
            end
         end
         CMD_SET_MASK: begin
            wr_en = 1'b1;
            case (how_type'(req.mask_how))
               HOW_REPLACE: nblk = sel & ~PROT_MASK;
               HOW_ADD:     nblk = (blk | sel) & ~PROT_MASK;
               HOW_REMOVE:  nblk = blk & ~sel & ~PROT_MASK;
               default: begin
                  rsp.status = ST_BAD_HOW;
                  wr_en      = 1'b0;
               end
            endcase
         end
         CMD_DISPATCH: begin
            if (ready == '0) begin
               rsp.status = ST_NONE_PENDING;
            end else begin
               npend = pend & ~(MASK_W'(1) << pick);
               wr_en = 1'b1;
               rsp.picked_signal = pick;
               case (handler_type'(hpick))
                  HDL_IGNORE:  rsp.status = ST_IGNORED;
                  HDL_DEFAULT: begin
                     case (default_kind({1'b0, pick}))
                        DK_IGNORE: rsp.status = ST_DEF_IGNORE;
                        DK_STOP:   rsp.status = ST_DEF_STOP;
                        default: begin
                           rsp.status      = ST_DEF_TERM;
                           rsp.proc_action = ACT_TERM;
                        end
                     endcase
                  end
                  default:     rsp.status = ST_USER;
               endcase
            end
         end
         CMD_QUERY: begin
         end
         default: begin
            rsp.status = ST_BAD_ARG;
         end
      endcase
      rsp.pending_out = npend;
      rsp.blocked_out = (cmd == CMD_SET_MASK) ? blk : nblk;
      if (!pid_ok || cmd == CMD_UNKNOWN) begin
         wr_en = 1'b0;
         rsp   = '0;
         rsp.status = ST_BAD_ARG;
      end
   end

endmodule
